FILE: design/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median core
// Sizes of the window and the sample, and the link between neighbor cells.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W       = $clog2(MAX_WINDOW);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [AGE_W-1:0]              age_t;

  typedef struct packed {
    logic    gt;
    sample_t value;
    age_t    age;
  } link_t;

endpackage

FILE: design/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one sample and its age, and on each item takes its new contents from
// itself, a neighbor or the new sample so that the row stays sorted.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    clr,
  input  logic    load,
  input  age_t    idx,
  input  age_t    len_m1,
  input  sample_t x,
  input  link_t   left,
  input  link_t   right,
  input  logic    kill_in,
  output link_t   self,
  output logic    kill_out
);

  sample_t value;
  age_t    age;
  sample_t value_next;
  age_t    age_next;
  logic    gt;
  logic    cr;
  logic    own_kill;

  assign gt       = value > x;
  assign own_kill = age == len_m1;
  assign cr       = (idx == len_m1) ? 1'b1 : right.gt;
  assign kill_out = kill_in | own_kill;
  assign self     = '{gt: gt, value: value, age: age};

  always_comb begin
    value_next = value;
    age_next   = age + age_t'(1);
    if (kill_in) begin
      if (gt) begin
        value_next = value;
        age_next   = age + age_t'(1);
      end else if (cr) begin
        value_next = x;
        age_next   = '0;
      end else begin
        value_next = right.value;
        age_next   = right.age + age_t'(1);
      end
    end else if (own_kill) begin
      if (left.gt) begin
        value_next = left.value;
        age_next   = left.age + age_t'(1);
      end else if (cr) begin
        value_next = x;
        age_next   = '0;
      end else begin
        value_next = right.value;
        age_next   = right.age + age_t'(1);
      end
    end else begin
      if (left.gt) begin
        value_next = left.value;
        age_next   = left.age + age_t'(1);
      end else if (gt) begin
        value_next = x;
        age_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      value <= '0;
      age   <= idx;
    end else if (load) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

FILE: design/swm_mid.sv
// ----------------------------------------------------------------------------
// swm_mid: median pick from the sorted row
// Selects the middle cell or middle pair and takes the floor average.
// ----------------------------------------------------------------------------
module swm_mid import swm_pkg::*; (
  input  sample_t vals [MAX_WINDOW],
  input  age_t    len_m1,
  output sample_t median
);

  age_t                         lo;
  age_t                         hi;
  logic signed [SAMPLE_BITS:0]  sum;

  assign lo     = {1'b0, len_m1[AGE_W-1:1]};
  assign hi     = lo + age_t'(len_m1[0]);
  assign sum    = {vals[lo][SAMPLE_BITS-1], vals[lo]} + {vals[hi][SAMPLE_BITS-1], vals[hi]};
  assign median = sum[SAMPLE_BITS:1];

endmodule

FILE: design/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_core: running median over the last window_len samples
// Sorted insertion chain of cells with a registered median output.
// ----------------------------------------------------------------------------
// Each item enters a row of sixteen cells that keep the window sorted with the
// age of every sample; as each item is taken the oldest sample leaves and the
// new one takes its sorted place. The median is picked from the row and
// registered at the output, and one item is taken per clock as long as the
// output side is not stalled. Writing window_len clears the window to zero;
// lengths of zero act as one and lengths above sixteen act as sixteen.
module sliding_window_median_core import swm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  sample_t          sample,
  output logic             out_valid,
  input  logic             out_stall,
  output sample_t          median,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] window_len
);

  age_t    len_m1;
  age_t    len_m1_next;
  logic    busy;
  logic    load;
  logic    out_load;
  logic    cfg_write;
  sample_t mid_value;
  sample_t vals [MAX_WINDOW];
  link_t   links [MAX_WINDOW];
  link_t   rights [MAX_WINDOW];
  link_t   lefts [MAX_WINDOW];
  logic [MAX_WINDOW:0] kills;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_load  = busy && (!out_valid || !out_stall);
  assign in_stall  = busy && !out_load;
  assign load      = in_valid && !in_stall;
  assign kills[0]  = 1'b0;

  always_comb begin
    if (window_len == '0) begin
      len_m1_next = '0;
    end else if (window_len > LEN_W'(MAX_WINDOW)) begin
      len_m1_next = age_t'(MAX_WINDOW - 1);
    end else begin
      len_m1_next = age_t'(window_len - LEN_W'(1));
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{gt: 1'b0, value: '0, age: '0};
    end else begin : g_mid
      assign lefts[i] = links[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign rights[i] = '{gt: 1'b1, value: '0, age: '0};
    end else begin : g_inner
      assign rights[i] = links[i+1];
    end
    assign vals[i] = links[i].value;

    swm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr      (cfg_write),
      .load     (load),
      .idx      (age_t'(i)),
      .len_m1   (len_m1),
      .x        (sample),
      .left     (lefts[i]),
      .right    (rights[i]),
      .kill_in  (kills[i]),
      .self     (links[i]),
      .kill_out (kills[i+1])
    );
  end

  swm_mid u_mid (
    .vals   (vals),
    .len_m1 (len_m1),
    .median (mid_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len_m1    <= age_t'(MAX_WINDOW - 1);
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        len_m1 <= len_m1_next;
      end
      busy <= load || (busy && !out_load);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median <= mid_value;
    end
  end

  a_accept_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy)
    else $error("accepted item did not mark the median stage busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result appeared without an item in the median stage");

  a_busy_drains: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_stall) |=> out_valid)
    else $error("pending median was not moved to the output register");

endmodule
